### hw/rtl/live_interval_interference_tracker_macros.svh
// Assertion helpers for the live interval tracker.
`ifndef LIVE_INTERVAL_INTERFERENCE_TRACKER_MACROS_SVH
`define LIVE_INTERVAL_INTERFERENCE_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define LITT_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("litt check failed");
// Next-cycle implication.
`define LITT_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("litt next-cycle check failed");
`else
`define LITT_CHECK(lbl, ante, cons)
`define LITT_CHECK_NEXT(lbl, ante, cons)
`endif

`endif

### hw/rtl/litt_pkg.sv
package litt_pkg;

    localparam int NUM_REGS_DEF  = 64;
    localparam int MAX_INSTR_DEF = 65535;

    localparam int IDX_W = 16;   // instruction index width
    localparam int REG_W = 6;    // register number width
    localparam int CNT_W = 7;    // register count width
    localparam int ROW_W = 64;   // interference row width

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_INSTR = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    localparam logic [2:0] OP_LOADCONST = 3'd0;
    localparam logic [2:0] OP_RETURN    = 3'd1;
    localparam logic [2:0] OP_ADD       = 3'd2;
    localparam logic [2:0] OP_MULT      = 3'd3;

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_ROW  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_EMIT,
        ST_Q_ADDR,
        ST_Q_FETCH,
        ST_Q_SCAN,
        ST_Q_EMIT
    } state_t;

    // Live interval of one register; an unused register is [-1,-1].
    typedef struct packed {
        logic             used;
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] last;
    } interval_t;

endpackage

### hw/rtl/litt_ram.sv
module litt_ram
    import litt_pkg::*;
#(
    parameter int WIDTH = IDX_W,
    parameter int DEPTH = NUM_REGS_DEF
)(
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/litt_overlap.sv
module litt_overlap
    import litt_pkg::*;
(
    input  interval_t q_iv,
    input  interval_t j_iv,
    output logic      hit
);

    logic both_unused;
    logic both_used;
    logic spans_meet;

    // unused intervals sit at -1: they meet each other and nothing else
    assign both_unused = !q_iv.used && !j_iv.used;
    assign both_used   = q_iv.used && j_iv.used;
    assign spans_meet  = (j_iv.first <= q_iv.last) && (j_iv.last >= q_iv.first);
    assign hit         = both_unused || (both_used && spans_meet);

endmodule

### hw/rtl/live_interval_interference_tracker.sv
// Live interval interference tracker. Accepts clear, instruction and query transactions
// one at a time (in_ready only while idle). Loadconst and return mark their destination;
// add and mult also mark both sources, then hand each dependency edge to the output
// register, waiting while it is full. A query of an in-range register scans
// min(num_registers, NUM_REGS) entries, since one overlap comparator walks the first/last
// tables one entry per cycle through their single read ports; an out-of-range query goes
// straight to its result. Instruction marks use one table write port per cycle. A finished
// result waits in the output register while the next transaction is taken.
`include "live_interval_interference_tracker_macros.svh"

module live_interval_interference_tracker
    import litt_pkg::*;
#(
    parameter int NUM_REGS         = NUM_REGS_DEF,
    parameter int MAX_INSTRUCTIONS = MAX_INSTR_DEF
)(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,

    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       action,
    input  logic [2:0]       opcode,
    input  logic [REG_W-1:0] dst_reg,
    input  logic [REG_W-1:0] src_a_reg,
    input  logic [REG_W-1:0] src_b_reg,
    input  logic [REG_W-1:0] query_reg,

    output logic             out_valid,
    input  logic             out_ready,
    output logic             kind,
    output logic [REG_W-1:0] node_reg,
    output logic [REG_W-1:0] other_reg,
    output logic [ROW_W-1:0] row_bits,
    output logic             last
);

    localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam logic [CNT_W-1:0] NUM_REGS_C = CNT_W'(NUM_REGS);
    localparam logic [IDX_W-1:0] MAX_IDX_C  = IDX_W'(MAX_INSTRUCTIONS);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]    num_regs_reg;
    logic [CNT_W-1:0]    n_eff;
    logic [NUM_REGS-1:0] valid_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    cur_idx_reg;
    logic [REG_W-1:0]    dst_q_reg, sa_q_reg, sb_q_reg, qry_reg;
    logic [1:0]          step_reg, mark_cnt_reg;
    logic                emit_a_reg, emit_b_reg;
    logic [CNT_W-1:0]    scan_reg;
    logic [CNT_W-1:0]    scan_plus;
    logic [ROW_W-1:0]    row_reg;
    interval_t           q_iv_reg;
    interval_t           j_iv;
    logic                hit;

    logic                out_valid_reg, out_kind_reg, out_last_reg;
    logic [REG_W-1:0]    out_node_reg, out_other_reg;
    logic [ROW_W-1:0]    out_row_reg;

    logic                accept;
    logic                slot_free;
    logic [REG_W-1:0]    mark_sel;
    logic                mark_in_range;
    logic [AW-1:0]       mark_addr;
    logic                first_we, last_we;
    logic [AW-1:0]       rd_addr;
    logic [IDX_W-1:0]    first_rdata, last_rdata;
    logic                load_edge, load_row;
    logic                is_mark_op, is_edge_op;
    logic                dst_in, sa_in, sb_in, q_in;

    assign n_eff     = (num_regs_reg > NUM_REGS_C) ? NUM_REGS_C : num_regs_reg;
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign scan_plus = scan_reg + 1'b1;

    assign is_edge_op = (opcode == OP_ADD) || (opcode == OP_MULT);
    assign is_mark_op = (opcode == OP_LOADCONST) || (opcode == OP_RETURN) || is_edge_op;
    assign dst_in     = {1'b0, dst_reg} < n_eff;
    assign sa_in      = {1'b0, src_a_reg} < n_eff;
    assign sb_in      = {1'b0, src_b_reg} < n_eff;
    assign q_in       = {1'b0, query_reg} < n_eff;

    always_comb
    begin
        unique case (step_reg)
            2'd0:    mark_sel = dst_q_reg;
            2'd1:    mark_sel = sa_q_reg;
            default: mark_sel = sb_q_reg;
        endcase
    end

    assign mark_in_range = {1'b0, mark_sel} < n_eff;
    assign mark_addr     = mark_sel[AW-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (action == ACT_INSTR && is_mark_op)
                        state_next = ST_MARK;
                    else if (action == ACT_QUERY)
                        state_next = q_in ? ST_Q_ADDR : ST_Q_EMIT;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_MARK:
            begin
                if (step_reg == mark_cnt_reg)
                    state_next = (emit_a_reg || emit_b_reg) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (slot_free && !(emit_a_reg && emit_b_reg))
                    state_next = ST_IDLE;
            end
            ST_Q_ADDR:  state_next = ST_Q_FETCH;
            ST_Q_FETCH: state_next = ST_Q_SCAN;
            ST_Q_SCAN:
            begin
                if (scan_plus == n_eff)
                    state_next = ST_Q_EMIT;
            end
            ST_Q_EMIT:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready  = 1'b0;
        first_we  = 1'b0;
        last_we   = 1'b0;
        load_edge = 1'b0;
        load_row  = 1'b0;
        rd_addr   = scan_reg[AW-1:0];
        unique case (state_reg)
            ST_IDLE:   in_ready = 1'b1;
            ST_MARK:
            begin
                first_we = mark_in_range && !valid_reg[mark_addr];
                last_we  = mark_in_range;
            end
            ST_EMIT:   load_edge = slot_free;
            ST_Q_ADDR: rd_addr = qry_reg[AW-1:0];
            ST_Q_SCAN: rd_addr = scan_plus[AW-1:0];
            ST_Q_EMIT: load_row = slot_free;
            default:   in_ready = 1'b0;
        endcase
    end

    litt_ram #(.WIDTH(IDX_W), .DEPTH(NUM_REGS)) u_first_ram (
        .clk   (clk),
        .we    (first_we),
        .waddr (mark_addr),
        .wdata (cur_idx_reg),
        .raddr (rd_addr),
        .rdata (first_rdata)
    );

    litt_ram #(.WIDTH(IDX_W), .DEPTH(NUM_REGS)) u_last_ram (
        .clk   (clk),
        .we    (last_we),
        .waddr (mark_addr),
        .wdata (cur_idx_reg),
        .raddr (rd_addr),
        .rdata (last_rdata)
    );

    always_comb
    begin
        j_iv.used  = valid_reg[scan_reg[AW-1:0]];
        j_iv.first = first_rdata;
        j_iv.last  = last_rdata;
    end

    litt_overlap u_overlap (
        .q_iv (q_iv_reg),
        .j_iv (j_iv),
        .hit  (hit)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            num_regs_reg <= NUM_REGS_C;
            valid_reg    <= '0;
            idx_reg      <= '0;
            step_reg     <= '0;
            emit_a_reg   <= 1'b0;
            emit_b_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                num_regs_reg <= cfg_wdata;

            if (accept && action == ACT_CLEAR)
            begin
                valid_reg <= '0;
                idx_reg   <= '0;
            end

            if (accept && action == ACT_INSTR)
            begin
                if (idx_reg < MAX_IDX_C)
                    idx_reg <= idx_reg + 1'b1;
                step_reg   <= '0;
                emit_a_reg <= is_edge_op && dst_in && sa_in;
                emit_b_reg <= is_edge_op && dst_in && sb_in;
            end

            if (state_reg == ST_MARK)
            begin
                step_reg <= step_reg + 1'b1;
                if (mark_in_range)
                    valid_reg[mark_addr] <= 1'b1;
            end

            if (load_edge)
            begin
                if (emit_a_reg)
                    emit_a_reg <= 1'b0;
                else
                    emit_b_reg <= 1'b0;
            end
        end
    end

    // transaction payload and scan datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_idx_reg  <= idx_reg;
            dst_q_reg    <= dst_reg;
            sa_q_reg     <= src_a_reg;
            sb_q_reg     <= src_b_reg;
            qry_reg      <= query_reg;
            mark_cnt_reg <= is_edge_op ? 2'd2 : 2'd0;
            scan_reg     <= '0;
            row_reg      <= '0;
        end
        if (state_reg == ST_Q_FETCH)
        begin
            q_iv_reg.used  <= valid_reg[qry_reg[AW-1:0]];
            q_iv_reg.first <= first_rdata;
            q_iv_reg.last  <= last_rdata;
        end
        if (state_reg == ST_Q_SCAN)
        begin
            scan_reg <= scan_plus;
            row_reg  <= row_reg | ({{(ROW_W-1){1'b0}}, hit} << scan_reg[REG_W-1:0]);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_edge || load_row)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_edge)
        begin
            out_kind_reg  <= KIND_EDGE;
            out_node_reg  <= dst_q_reg;
            out_other_reg <= emit_a_reg ? sa_q_reg : sb_q_reg;
            out_row_reg   <= '0;
            out_last_reg  <= emit_a_reg ? !emit_b_reg : 1'b1;
        end
        else if (load_row)
        begin
            out_kind_reg  <= KIND_ROW;
            out_node_reg  <= qry_reg;
            out_other_reg <= '0;
            out_row_reg   <= row_reg;
            out_last_reg  <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign node_reg  = out_node_reg;
    assign other_reg = out_other_reg;
    assign row_bits  = out_row_reg;
    assign last      = out_last_reg;

    `LITT_CHECK(a_scan_bound, state_reg == ST_Q_SCAN, scan_reg < n_eff)
    `LITT_CHECK(a_idx_sat, 1'b1, idx_reg <= MAX_IDX_C)
    `LITT_CHECK_NEXT(a_clear_empties, accept && action == ACT_CLEAR, valid_reg == '0 && idx_reg == '0)
    `LITT_CHECK(a_row_width, out_valid_reg, (out_row_reg >> NUM_REGS) == '0)

endmodule
